// ===== hdl/hmng_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmng_pkg
// Types and constants shared by the heightmap normal generator modules.
// ----------------------------------------------------------------------------
package hmng_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hmng_in_t;

  typedef struct packed {
    logic        [9:0]  column;
    logic        [9:0]  row;
    logic        [19:0] vertex_height;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               final_vertex;
  } hmng_out_t;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_HEIGHT = 2'd2;

  localparam logic [19:0] HEIGHT_MAX = 20'hFFFFF;
  localparam logic [14:0] NORMAL_ONE = 15'd16384;
  localparam logic [20:0] NY_MAG     = 21'd512;
  localparam logic [10:0] HEIGHT_CAP = 11'd1024;

  localparam int DIV_NUM_W  = 45;
  localparam int DIV_DEN_W  = 31;
  localparam int SQRT_IN_W  = 62;
  localparam int SQRT_OUT_W = 31;

endpackage
`default_nettype wire

// ===== hdl/hmng_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmng_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hmng_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hdl/hmng_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmng_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hmng_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [hmng_pkg::DIV_NUM_W-1:0]  num,
  input  logic [hmng_pkg::DIV_DEN_W-1:0]  den,
  output logic                            done,
  output logic [hmng_pkg::DIV_NUM_W-1:0]  quot,
  output logic [hmng_pkg::DIV_DEN_W-1:0]  rem
);
  import hmng_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [DIV_NUM_W-1:0] q_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;

  logic [DIV_DEN_W:0]   rs;
  logic [DIV_DEN_W:0]   rdiff;
  logic                 ge;

  assign rs    = {rem_r, q_r[DIV_NUM_W-1]};
  assign ge    = rs >= {1'b0, den_r};
  assign rdiff = rs - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_NUM_W-2:0], ge};
      rem_r <= ge ? rdiff[DIV_DEN_W-1:0] : rs[DIV_DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ===== hdl/hmng_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmng_isqrt
// Integer square root, floor(sqrt(n)), two radicand bits per cycle.
// ----------------------------------------------------------------------------
module hmng_isqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [hmng_pkg::SQRT_IN_W-1:0]   n,
  output logic                             done,
  output logic [hmng_pkg::SQRT_OUT_W-1:0]  root
);
  import hmng_pkg::*;

  localparam int CW = $clog2(SQRT_OUT_W + 1);
  localparam int RW = SQRT_OUT_W + 2;

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  logic [SQRT_IN_W-1:0]  n_r;
  logic [RW-1:0]         rem_r;
  logic [SQRT_OUT_W-1:0] root_r;

  logic [RW+1:0]         rs;
  logic [RW+1:0]         trial;
  logic [RW+1:0]         rdiff;
  logic                  ge;

  assign rs    = {rem_r, n_r[SQRT_IN_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign ge    = rs >= trial;
  assign rdiff = rs - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(SQRT_OUT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= n;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= {n_r[SQRT_IN_W-3:0], 2'b00};
      rem_r  <= ge ? rdiff[RW-1:0] : rs[RW-1:0];
      root_r <= {root_r[SQRT_OUT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== hdl/heightmap_normal_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_normal_generator
// Turns raster heightmap pixels into vertices with height and unit normal,
// one row behind the input, using three rotating line stores.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+-------------------------------
//   input    | in_valid/in_ready/in_data      | pixel sample or drain tick
//   output   | out_valid/out_ready/out_data   | vertex: position, height, normal
//   config   | psel/penable/pwrite/paddr/...  | map_width, map_height, max_height
//
// A pixel of row 0 only computes and stores its height; a pixel that yields a vertex
// also runs the bit-serial square root and three divides on the shared serial
// divider. A drain runs a position divide in place of the height steps.
// A new item is taken while the previous vertex waits in the output register.
// Reset is synchronous; the line stores are not cleared.
// ----------------------------------------------------------------------------
module heightmap_normal_generator #(
  parameter int MAX_WIDTH        = 1024,
  parameter int COLOR_SCALE_LOG2 = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hmng_pkg::hmng_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hmng_pkg::hmng_out_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import hmng_pkg::*;

  localparam int          AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int          WLIM   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam logic [10:0] WLIM_V = 11'(WLIM);
  localparam logic [25:0] T_ONE  = 26'(1) << COLOR_SCALE_LOG2;
  localparam logic [44:0] RND    = 45'(1) << (COLOR_SCALE_LOG2 - 1);
  localparam logic [41:0] NY_SQ  = 42'(262144);

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_HGT0 = 19'h00002,
    S_HGT1 = 19'h00004,
    S_HGT2 = 19'h00008,
    S_HGT3 = 19'h00010,
    S_WR   = 19'h00020,
    S_DCHK = 19'h00040,
    S_DIVP = 19'h00080,
    S_RD0  = 19'h00100,
    S_RD1  = 19'h00200,
    S_RD2  = 19'h00400,
    S_RD3  = 19'h00800,
    S_NRM0 = 19'h01000,
    S_NRM1 = 19'h02000,
    S_NRM2 = 19'h04000,
    S_SQRT = 19'h08000,
    S_NST  = 19'h10000,
    S_NDIV = 19'h20000,
    S_OUT  = 19'h40000
  } state_t;

  // configuration
  logic [10:0] map_width_r;
  logic [10:0] map_height_r;
  logic [9:0]  max_height_r;
  logic        cfg_we;
  logic [10:0] w_eff;
  logic [10:0] h_eff;

  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 11'd2;
      map_height_r <= 11'd2;
      max_height_r <= 10'd1;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_MAP_WIDTH:  map_width_r  <= pwdata[10:0];
        REG_MAP_HEIGHT: map_height_r <= pwdata[10:0];
        REG_MAX_HEIGHT: max_height_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAP_WIDTH:  prdata = {21'd0, map_width_r};
      REG_MAP_HEIGHT: prdata = {21'd0, map_height_r};
      REG_MAX_HEIGHT: prdata = {22'd0, max_height_r};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    priority if (map_width_r < 11'd2) w_eff = 11'd2;
    else if (map_width_r > WLIM_V)    w_eff = WLIM_V;
    else                              w_eff = map_width_r;
    priority if (map_height_r < 11'd2)  h_eff = 11'd2;
    else if (map_height_r > HEIGHT_CAP) h_eff = HEIGHT_CAP;
    else                                h_eff = map_height_r;
  end

  // control state
  state_t      state_r, state_nxt;
  logic [10:0] col_r, col_nxt;
  logic [10:0] row_r, row_nxt;
  logic [19:0] epos_r, epos_nxt;
  logic [1:0]  rot_r, rot_nxt;
  logic        out_valid_r, out_valid_nxt;

  // item registers
  logic                drain_r;
  logic                emit_r;
  logic                fin_r;
  logic [7:0]          red_r, green_r, blue_r;
  logic [10:0]         cidx_r;
  logic [10:0]         vrow_r;
  logic [20:0]         wh_r;
  logic [15:0]         rg_r;
  logic [23:0]         rgb_r;
  logic [35:0]         prod_r;
  logic [19:0]         hv_r;
  logic [19:0]         hl_r, hr_r, hd_r, hu_r, own_r;
  logic signed [20:0]  nx_r, nz_r;
  logic [39:0]         nx2_r, nz2_r;
  logic [30:0]         len_r;
  logic [1:0]          comp_r;
  logic [15:0]         nxo_r, nyo_r, nzo_r;
  logic [20:0]         eposi_r;
  hmng_out_t           out_data_r;

  logic        col_over;
  logic [10:0] r_use;
  logic [1:0]  rot_inc;
  logic [10:0] cnext;
  logic        div_start, div_done, sqrt_start, sqrt_done;
  logic        low_we;
  logic        load_out;
  logic [DIV_NUM_W-1:0] div_num, div_quot, norm_num;
  logic [DIV_DEN_W-1:0] div_den, div_rem;
  logic [SQRT_IN_W-1:0] sqrt_n;
  logic [SQRT_OUT_W-1:0] sqrt_root;
  logic [41:0] s_sum;
  logic signed [41:0] nx_sq, nz_sq;
  logic [20:0] mag;
  logic        neg;
  logic [14:0] qclamp;
  logic [15:0] qv, cv;
  logic [25:0] t_val;
  logic [35:0] prod_c;
  logic [44:0] rsum, vsh;
  logic [19:0] hv_c;
  logic        c_first, c_last;
  logic [21:0] wh_c;
  logic [21:0] eposi_c;
  logic [19:0] up_rdata, mid_rdata, low_rdata;

  assign col_over = col_r >= w_eff;
  assign r_use    = col_over ? row_r + 11'd1 : row_r;
  assign rot_inc  = (rot_r == 2'd2) ? 2'd0 : rot_r + 2'd1;
  assign cnext    = cidx_r + 11'd1;
  assign c_first  = cidx_r == 11'd0;
  assign c_last   = ({1'b0, cidx_r} + 12'd1) >= {1'b0, w_eff};
  assign in_ready = state_r == S_IDLE;

  // next-state and counter updates
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    epos_nxt      = epos_r;
    rot_nxt       = rot_r;
    out_valid_nxt = out_valid_r;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;
    low_we        = 1'b0;
    load_out      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_PIXEL) begin
            if (row_r < h_eff) begin
              if (col_over) begin
                col_nxt = '0;
                row_nxt = r_use;
                rot_nxt = rot_inc;
              end
              if (r_use < h_eff) begin
                state_nxt = S_HGT0;
              end
            end
          end else if (row_r >= h_eff) begin
            state_nxt = S_DCHK;
          end
        end
      end
      S_HGT0: state_nxt = S_HGT1;
      S_HGT1: state_nxt = S_HGT2;
      S_HGT2: state_nxt = S_HGT3;
      S_HGT3: state_nxt = S_WR;
      S_WR: begin
        low_we = 1'b1;
        if (emit_r) begin
          state_nxt = S_RD0;
        end else begin
          state_nxt = S_IDLE;
          if (cnext >= w_eff) begin
            col_nxt = '0;
            row_nxt = row_r + 11'd1;
            rot_nxt = rot_inc;
          end else begin
            col_nxt = cnext;
          end
        end
      end
      S_DCHK: begin
        if ({1'b0, epos_r} >= wh_r) begin
          col_nxt   = '0;
          row_nxt   = '0;
          epos_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVP;
        end
      end
      S_DIVP: if (div_done) state_nxt = S_RD0;
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_RD2;
      S_RD2:  state_nxt = S_RD3;
      S_RD3:  state_nxt = S_NRM0;
      S_NRM0: state_nxt = S_NRM1;
      S_NRM1: state_nxt = S_NRM2;
      S_NRM2: begin
        sqrt_start = 1'b1;
        state_nxt  = S_SQRT;
      end
      S_SQRT: if (sqrt_done) state_nxt = S_NST;
      S_NST: begin
        div_start = 1'b1;
        state_nxt = S_NDIV;
      end
      S_NDIV: begin
        if (div_done) begin
          state_nxt = (comp_r == COMP_Z) ? S_OUT : S_NST;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (drain_r) begin
            if (fin_r) begin
              col_nxt  = '0;
              row_nxt  = '0;
              epos_nxt = '0;
            end else begin
              epos_nxt = epos_r + 20'd1;
            end
          end else begin
            epos_nxt = eposi_r[19:0];
            if (cnext >= w_eff) begin
              col_nxt = '0;
              row_nxt = row_r + 11'd1;
              rot_nxt = rot_inc;
            end else begin
              col_nxt = cnext;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      epos_r      <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      epos_r      <= epos_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // height arithmetic
  assign t_val  = T_ONE + {1'b0, rgb_r, 1'b0};
  assign prod_c = max_height_r * t_val;
  assign rsum   = {1'b0, prod_r, 8'd0} + RND;
  assign vsh    = rsum >> COLOR_SCALE_LOG2;
  assign hv_c   = (|vsh[44:20]) ? HEIGHT_MAX : vsh[19:0];
  assign wh_c   = w_eff * h_eff;
  assign eposi_c = vrow_r * w_eff + {11'd0, cidx_r} + 22'd1;

  // normal arithmetic
  assign nx_sq  = nx_r * nx_r;
  assign nz_sq  = nz_r * nz_r;
  assign s_sum  = {2'b00, nx2_r} + {2'b00, nz2_r} + NY_SQ;
  assign sqrt_n = {s_sum, 20'd0};

  always_comb begin
    unique case (comp_r)
      COMP_X: begin
        neg = nx_r[20];
        mag = nx_r[20] ? 21'(-nx_r) : 21'(nx_r);
      end
      COMP_Y: begin
        neg = 1'b0;
        mag = NY_MAG;
      end
      COMP_Z: begin
        neg = nz_r[20];
        mag = nz_r[20] ? 21'(-nz_r) : 21'(nz_r);
      end
      default: begin
        neg = 1'b0;
        mag = '0;
      end
    endcase
  end

  assign norm_num = {mag, 24'd0} + 45'(len_r >> 1);
  assign div_num  = (state_r == S_NST) ? norm_num : {25'd0, epos_r};
  assign div_den  = (state_r == S_NST) ? len_r : {20'd0, w_eff};
  assign qclamp   = (div_quot > 45'(NORMAL_ONE)) ? NORMAL_ONE : div_quot[14:0];
  assign qv       = {1'b0, qclamp};
  assign cv       = neg ? (16'd0 - qv) : qv;

  // item datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        drain_r <= in_data.cmd;
        red_r   <= in_data.red;
        green_r <= in_data.green;
        blue_r  <= in_data.blue;
        cidx_r  <= col_over ? 11'd0 : col_r;
        emit_r  <= r_use != 11'd0;
        vrow_r  <= r_use - 11'd1;
        wh_r    <= wh_c[20:0];
      end
      S_HGT0: rg_r   <= red_r * green_r;
      S_HGT1: rgb_r  <= rg_r * blue_r;
      S_HGT2: prod_r <= prod_c;
      S_HGT3: hv_r   <= hv_c;
      S_DCHK: fin_r  <= {1'b0, epos_r} == (wh_r - 21'd1);
      S_DIVP: begin
        if (div_done) begin
          cidx_r <= div_rem[10:0];
          vrow_r <= div_quot[10:0];
        end
      end
      S_RD1: begin
        hd_r <= (vrow_r != 11'd0) ? up_rdata : 20'd0;
        hl_r <= c_first ? 20'd0 : mid_rdata;
        if (drain_r) begin
          hu_r <= (({1'b0, vrow_r} + 12'd1) < {1'b0, h_eff}) ? low_rdata : 20'd0;
        end else begin
          hu_r <= hv_r;
        end
      end
      S_RD2: own_r <= mid_rdata;
      S_RD3: hr_r  <= c_last ? 20'd0 : mid_rdata;
      S_NRM0: begin
        nx_r    <= $signed({1'b0, hl_r}) - $signed({1'b0, hr_r});
        nz_r    <= $signed({1'b0, hd_r}) - $signed({1'b0, hu_r});
        eposi_r <= eposi_c[20:0];
      end
      S_NRM1: begin
        nx2_r <= nx_sq[39:0];
        nz2_r <= nz_sq[39:0];
      end
      S_SQRT: begin
        if (sqrt_done) begin
          len_r  <= sqrt_root;
          comp_r <= COMP_X;
        end
      end
      S_NDIV: begin
        if (div_done) begin
          unique case (comp_r)
            COMP_X:  nxo_r <= cv;
            COMP_Y:  nyo_r <= cv;
            default: nzo_r <= cv;
          endcase
          comp_r <= comp_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.column        <= cidx_r[9:0];
      out_data_r.row           <= vrow_r[9:0];
      out_data_r.vertex_height <= own_r;
      out_data_r.normal_x      <= nxo_r;
      out_data_r.normal_y      <= nyo_r;
      out_data_r.normal_z      <= nzo_r;
      out_data_r.final_vertex  <= drain_r & fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // line stores: bank rot_r holds the upper row, the next the middle row,
  // the one after that the row being written
  logic [1:0]    up_b, mid_b, low_b;
  logic [AW-1:0] up_addr, mid_addr, low_addr;
  logic [AW-1:0] bank_raddr [3];
  logic          bank_we    [3];
  logic [19:0]   bank_rdata [3];

  assign up_b  = rot_r;
  assign mid_b = rot_inc;
  assign low_b = (rot_r == 2'd0) ? 2'd2 : rot_r - 2'd1;

  assign up_addr  = AW'(cidx_r);
  assign low_addr = AW'(cidx_r);

  always_comb begin
    unique case (state_r)
      S_RD0:   mid_addr = c_first ? AW'(cidx_r) : AW'(cidx_r - 11'd1);
      S_RD2:   mid_addr = c_last ? AW'(cidx_r) : AW'(cnext);
      default: mid_addr = AW'(cidx_r);
    endcase
  end

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      if (2'(b) == up_b) begin
        bank_raddr[b] = up_addr;
      end else if (2'(b) == mid_b) begin
        bank_raddr[b] = mid_addr;
      end else begin
        bank_raddr[b] = low_addr;
      end
      bank_we[b] = low_we && (2'(b) == low_b);
    end
  end

  assign up_rdata  = bank_rdata[up_b];
  assign mid_rdata = bank_rdata[mid_b];
  assign low_rdata = bank_rdata[low_b];

  for (genvar g = 0; g < 3; g++) begin : g_bank
    hmng_ram #(
      .WIDTH (20),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (low_addr),
      .wdata (hv_r),
      .raddr (bank_raddr[g]),
      .rdata (bank_rdata[g])
    );
  end

  hmng_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  hmng_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n     (sqrt_n),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

endmodule
`default_nettype wire

// ===== hdl/hmng_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hmng_checker
// Port-level checks for the heightmap normal generator.
// ----------------------------------------------------------------------------
module hmng_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input hmng_pkg::hmng_out_t out_data,
  input logic                pready
);
  import hmng_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed during a stalled transfer");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ny_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.normal_y > 16'sd0) && (out_data.normal_y <= 16'sd16384))
    else $error("normal y out of range");

  a_nxz_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.normal_x <= 16'sd16384) && (out_data.normal_x >= -16'sd16384)
              && (out_data.normal_z <= 16'sd16384) && (out_data.normal_z >= -16'sd16384))
    else $error("normal x or z out of range");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind heightmap_normal_generator hmng_checker u_hmng_checker (.*);
`default_nettype wire
